>>> rtl/core/arp_pkg.sv
package arp_pkg;

  localparam int MaxNotes  = 64;
  localparam int CntW      = $clog2(MaxNotes + 1);
  localparam int FreqW     = 16;
  localparam int LenW      = 24;
  localparam int NumW      = 32;
  localparam int DenW      = 16;
  localparam int DivCntW   = $clog2(NumW);
  localparam int RunW      = 23;    // max product / 1000 fits here
  localparam int RemW      = 10;    // remainder of / 1000
  localparam int RemThresh = 5;     // fraction above 5/1000 adds a tail note
  localparam int QOne      = 256000; // 1000 in Q.8
  localparam int QShift    = 8;

  typedef enum logic [2:0] {
    StIdle,
    StLaunch,
    StDivCount,
    StDivRegular,
    StDivTail,
    StEmit
  } arp_state_t;

  typedef enum logic [1:0] {
    SelBase,
    SelSecond,
    SelThird
  } arp_sel_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quo;
    logic [DenW-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/arp_in_if.sv
interface arp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] base_frequency;
  logic [15:0] second_frequency;
  logic [15:0] third_frequency;
  logic [15:0] note_rate;
  logic [15:0] note_duration;

  modport source (
    output valid, base_frequency, second_frequency, third_frequency, note_rate,
           note_duration,
    input  ready
  );
  modport sink (
    input  valid, base_frequency, second_frequency, third_frequency, note_rate,
           note_duration,
    output ready
  );
endinterface

>>> rtl/core/arp_out_if.sv
interface arp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tone_frequency;
  logic [23:0] tone_length;
  logic        last_tone;

  modport source (
    output valid, tone_frequency, tone_length, last_tone,
    input  ready
  );
  modport sink (
    input  valid, tone_frequency, tone_length, last_tone,
    output ready
  );
endinterface

>>> rtl/core/arp_div.sv
// Restoring divider, one quotient bit per cycle.
module arp_div (
  input  logic               clk,
  input  logic               rst,
  input  arp_pkg::div_req_t  req,
  output arp_pkg::div_rsp_t  rsp
);

  logic                         busy;
  logic                         done;
  logic [arp_pkg::NumW-1:0]     quo;
  logic [arp_pkg::DenW-1:0]     rem;
  logic [arp_pkg::DenW-1:0]     den;
  logic [arp_pkg::DivCntW-1:0]  cnt;

  logic [arp_pkg::DenW:0]       trial;
  logic [arp_pkg::DenW:0]       diff;
  logic                         q_bit;
  logic [arp_pkg::DenW-1:0]     rem_next;

  always_comb begin
    trial    = {rem, quo[arp_pkg::NumW-1]};
    diff     = trial - {1'b0, den};
    q_bit    = (trial >= {1'b0, den});
    rem_next = q_bit ? diff[arp_pkg::DenW-1:0] : trial[arp_pkg::DenW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse once, after the last quotient bit
      done <= !req.start && busy && (cnt == arp_pkg::DivCntW'(arp_pkg::NumW - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == arp_pkg::DivCntW'(arp_pkg::NumW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      quo <= {quo[arp_pkg::NumW-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

>>> rtl/core/arpeggio_note_splitter.sv
// Arpeggio note splitter.
// note_in takes one request: three tone frequencies, a rate in sub-notes per
// 1000 time units and a total duration. tone_out returns the run of sub-notes,
// frequencies cycling base, second, third, each with a Q16.8 length;
// last_tone marks the final one. A run with count zero returns nothing.
// Runs are cut at MaxNotes sub-notes.
// One shared restoring divider does all the divisions; rate*duration comes
// from a multiplier. After accept the launch state starts rate*duration /
// 1000 (count), then the regular length unless the count is zero, then the
// tail length when the remainder exceeds 5/1000. Sub-notes are loaded after
// the last division, one sub-note per cycle when the receiver is ready. An
// empty run frees the input as soon as the count division is done.
// note_in.ready is high only while idle; it returns as soon as the last
// sub-note sits in the output register, so the next request can start while
// that result waits.
// Receiver stall: the output register holds its request and the sequencer
// waits; nothing is dropped.
// Reset (rst, synchronous): sequencer to idle, output register empty.
module arpeggio_note_splitter (
  input  logic             clk,
  input  logic             rst,
  arp_in_if.sink           note_in,
  arp_out_if.source        tone_out
);

  arp_pkg::arp_state_t  state;
  arp_pkg::arp_state_t  state_next;
  arp_pkg::div_req_t    div_req;
  arp_pkg::div_rsp_t    div_rsp;

  // captured request
  logic [arp_pkg::FreqW-1:0] base_freq;
  logic [arp_pkg::FreqW-1:0] second_freq;
  logic [arp_pkg::FreqW-1:0] third_freq;
  logic [15:0]               rate;
  logic [15:0]               dur;

  // run description, filled in by the divisions
  logic [arp_pkg::RemW-1:0]  rem_q;
  logic                      extra;
  logic [arp_pkg::CntW-1:0]  emit_cnt;
  logic                      single;
  logic                      tail_ok;   // the last emitted note is the true end
  logic [arp_pkg::LenW-1:0]  regular;
  logic [arp_pkg::LenW-1:0]  tail;

  // emission
  logic [arp_pkg::CntW-1:0]  idx;
  arp_pkg::arp_sel_t         sel;
  logic                      out_valid;
  logic [arp_pkg::FreqW-1:0] out_freq;
  logic [arp_pkg::LenW-1:0]  out_len;
  logic                      out_last;

  logic                      accept;
  logic                      count_extra;
  logic [arp_pkg::RunW:0]    run_sum;
  logic                      load;
  logic                      last_item;
  logic [arp_pkg::FreqW-1:0] sel_freq;
  logic [arp_pkg::LenW-1:0]  sel_len;

  assign note_in.ready = (state == arp_pkg::StIdle);
  assign accept        = note_in.valid && note_in.ready;

  // count = whole + (remainder above threshold)
  assign count_extra = (div_rsp.rem > arp_pkg::DenW'(arp_pkg::RemThresh));
  assign run_sum     = {1'b0, div_rsp.quo[arp_pkg::RunW-1:0]}
                     + (arp_pkg::RunW + 1)'(count_extra);

  assign load      = (state == arp_pkg::StEmit) && (!out_valid || tone_out.ready);
  assign last_item = (idx == emit_cnt - 1'b1);

  arp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arp_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = rate;
    unique case (state)
      arp_pkg::StIdle: begin
        if (accept) state_next = arp_pkg::StLaunch;
      end
      arp_pkg::StLaunch: begin
        // product feeds the divider's dividend register directly
        div_req.start = 1'b1;
        div_req.num   = {16'b0, rate} * {16'b0, dur};
        div_req.den   = arp_pkg::DenW'(1000);
        state_next    = arp_pkg::StDivCount;
      end
      arp_pkg::StDivCount: begin
        if (div_rsp.done) begin
          if (run_sum == '0) begin
            state_next = arp_pkg::StIdle;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = arp_pkg::NumW'(arp_pkg::QOne) + arp_pkg::NumW'(rate >> 1);
            state_next    = arp_pkg::StDivRegular;
          end
        end
      end
      arp_pkg::StDivRegular: begin
        if (div_rsp.done) begin
          if (extra) begin
            div_req.start = 1'b1;
            div_req.num   = arp_pkg::NumW'({rem_q, 8'b0}) + arp_pkg::NumW'(rate >> 1);
            state_next    = arp_pkg::StDivTail;
          end else begin
            state_next = arp_pkg::StEmit;
          end
        end
      end
      arp_pkg::StDivTail: begin
        if (div_rsp.done) state_next = arp_pkg::StEmit;
      end
      arp_pkg::StEmit: begin
        if (load && last_item) state_next = arp_pkg::StIdle;
      end
      default: state_next = arp_pkg::StIdle;
    endcase
  end

  // tone select and length of the note being loaded
  always_comb begin
    unique case (sel)
      arp_pkg::SelSecond: sel_freq = second_freq;
      arp_pkg::SelThird:  sel_freq = third_freq;
      default:            sel_freq = base_freq;
    endcase
    priority if (last_item && single) begin
      sel_len = {dur, arp_pkg::QShift'(0)};
    end else if (last_item && tail_ok) begin
      sel_len = tail;
    end else begin
      sel_len = regular;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_freq   <= note_in.base_frequency;
      second_freq <= note_in.second_frequency;
      third_freq  <= note_in.third_frequency;
      rate        <= note_in.note_rate;
      dur         <= note_in.note_duration;
    end
    if (state == arp_pkg::StDivCount && div_rsp.done) begin
      rem_q    <= div_rsp.rem[arp_pkg::RemW-1:0];
      extra    <= count_extra;
      emit_cnt <= (run_sum > (arp_pkg::RunW + 1)'(arp_pkg::MaxNotes))
                ? arp_pkg::CntW'(arp_pkg::MaxNotes) : run_sum[arp_pkg::CntW-1:0];
      single   <= (run_sum == (arp_pkg::RunW + 1)'(1));
      tail_ok  <= (run_sum <= (arp_pkg::RunW + 1)'(arp_pkg::MaxNotes));
    end
    if (state == arp_pkg::StDivRegular && div_rsp.done) begin
      regular <= div_rsp.quo[arp_pkg::LenW-1:0];
      tail    <= div_rsp.quo[arp_pkg::LenW-1:0];
    end
    if (state == arp_pkg::StDivTail && div_rsp.done) begin
      tail <= div_rsp.quo[arp_pkg::LenW-1:0];
    end
    if (load) begin
      out_freq <= sel_freq;
      out_len  <= sel_len;
      out_last <= last_item;
    end
  end

  // run position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      sel       <= arp_pkg::SelBase;
    end else begin
      if (state == arp_pkg::StDivCount) begin
        idx <= '0;
        sel <= arp_pkg::SelBase;
      end else if (load) begin
        idx <= idx + 1'b1;
        unique case (sel)
          arp_pkg::SelBase:   sel <= arp_pkg::SelSecond;
          arp_pkg::SelSecond: sel <= arp_pkg::SelThird;
          default:            sel <= arp_pkg::SelBase;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (tone_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tone_out.valid          = out_valid;
  assign tone_out.tone_frequency = out_freq;
  assign tone_out.tone_length    = out_len;
  assign tone_out.last_tone      = out_last;

endmodule

>>> rtl/core/arp_checker.sv
module arp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_freq,
  input logic [23:0] out_len,
  input logic        out_last
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_freq) && $stable(out_len) && $stable(out_last))
    else $error("stalled result changed");

  // busy right after taking a note
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a run mid-way keeps the input closed
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input open during a run");

  // results need the divider; none start right after accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind arpeggio_note_splitter arp_checker u_arp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (note_in.valid),
  .in_ready  (note_in.ready),
  .out_valid (tone_out.valid),
  .out_ready (tone_out.ready),
  .out_freq  (tone_out.tone_frequency),
  .out_len   (tone_out.tone_length),
  .out_last  (tone_out.last_tone)
);
